FILE: rtl/three_channel_current_block_averager_assert.svh
// Assertion macros shared by the averager RTL.
// Depends on nothing; included by the top level.
`ifndef THREE_CHANNEL_CURRENT_BLOCK_AVERAGER_ASSERT_SVH
`define THREE_CHANNEL_CURRENT_BLOCK_AVERAGER_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define TCBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcba assertion failed");

// Condition implies consequence in the next cycle.
`define TCBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcba assertion failed");

`endif

FILE: rtl/tcba_pkg.sv
// Shared constants and types of the three-channel current averager.
// No dependencies; used by every module of the block.
package tcba_pkg;

  localparam int NCH        = 3;
  localparam int ADC_W      = 16;
  localparam int CUR_W      = 16;
  localparam int GAIN_W     = 24;
  localparam int WINDOW_DEF = 10;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd910236;
  localparam logic [GAIN_W-1:0] ROUND_HALF = 24'h800000;

  typedef enum logic {
    CMD_SAMPLE  = 1'b0,
    CMD_CAPTURE = 1'b1
  } cmd_t;

  // Per-item control that travels beside the lane pipelines.
  typedef struct packed {
    logic capture;
    logic fresh;
  } ctrl_t;

endpackage

FILE: rtl/tcba_lane.sv
// One channel lane: window accumulator, zero offset, offset subtract,
// gain multiply and rounding with saturation. Depends on tcba_pkg.
module tcba_lane #(
  parameter int WINDOW = tcba_pkg::WINDOW_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         accept,
  input  logic                         capture,
  input  logic                         close,
  input  logic [tcba_pkg::ADC_W-1:0]   adc,
  input  logic [tcba_pkg::GAIN_W-1:0]  gain,
  output logic [tcba_pkg::ADC_W-1:0]   raw,
  output logic [tcba_pkg::CUR_W-1:0]   cur
);

  localparam int SUM_W  = tcba_pkg::ADC_W + $clog2(WINDOW);
  localparam int PROD_W = SUM_W + tcba_pkg::GAIN_W;

  logic [SUM_W-1:0]           sum_r;
  logic [SUM_W-1:0]           sum_ext;
  logic [tcba_pkg::ADC_W-1:0] off_r;

  logic [SUM_W-1:0]           s1_sum_r;
  logic [tcba_pkg::ADC_W-1:0] s1_off_r;
  logic [tcba_pkg::ADC_W-1:0] s1_raw_r;
  logic [SUM_W-1:0]           s2_mag_r;
  logic [tcba_pkg::ADC_W-1:0] s2_raw_r;
  logic [PROD_W-1:0]          s3_prod_r;
  logic [tcba_pkg::ADC_W-1:0] s3_raw_r;

  logic [SUM_W-1:0] base;
  logic [SUM_W:0]   delta;
  logic             pos;
  logic [PROD_W:0]  rnd;
  logic [SUM_W:0]   quot;

  assign sum_ext = sum_r + SUM_W'(adc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      off_r <= '0;
    end else if (accept) begin
      if (capture) begin
        sum_r <= '0;
        off_r <= adc;
      end else if (close) begin
        sum_r <= '0;
      end else begin
        sum_r <= sum_ext;
      end
    end
  end

  // Offset correction: the window sum minus WINDOW times the zero count.
  assign base  = SUM_W'(WINDOW) * SUM_W'(s1_off_r);
  assign delta = {1'b0, s1_sum_r} - {1'b0, base};
  assign pos   = !delta[SUM_W] && (|delta[SUM_W-1:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sum_r  <= sum_ext;
      s1_off_r  <= off_r;
      s1_raw_r  <= capture ? '0 : adc;
      s2_mag_r  <= pos ? delta[SUM_W-1:0] : '0;
      s2_raw_r  <= s1_raw_r;
      s3_prod_r <= PROD_W'(s2_mag_r) * PROD_W'(gain);
      s3_raw_r  <= s2_raw_r;
    end
  end

  // Round half up, drop the Q24 fraction, then saturate to 16 bits.
  assign rnd  = {1'b0, s3_prod_r} + (PROD_W+1)'(tcba_pkg::ROUND_HALF);
  assign quot = rnd[PROD_W:tcba_pkg::GAIN_W];
  assign cur  = (|quot[SUM_W:tcba_pkg::CUR_W]) ? '1 : quot[tcba_pkg::CUR_W-1:0];
  assign raw  = s3_raw_r;

endmodule

FILE: rtl/tcba_merge.sv
// Merge stage: holds the three currents and registers the result item.
// Depends on tcba_pkg; fed by the three tcba_lane instances.
module tcba_merge (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       valid,
  input  tcba_pkg::ctrl_t            ctrl,
  input  logic [tcba_pkg::ADC_W-1:0] raw [tcba_pkg::NCH],
  input  logic [tcba_pkg::CUR_W-1:0] cur [tcba_pkg::NCH],
  output logic                       out_valid,
  output logic [tcba_pkg::ADC_W-1:0] out_raw [tcba_pkg::NCH],
  output logic [tcba_pkg::CUR_W-1:0] out_cur [tcba_pkg::NCH],
  output logic                       out_fresh
);

  logic [tcba_pkg::CUR_W-1:0] held_r   [tcba_pkg::NCH];
  logic [tcba_pkg::CUR_W-1:0] held_nxt [tcba_pkg::NCH];
  logic                       valid_r;
  logic                       fresh_r;
  logic [tcba_pkg::ADC_W-1:0] raw_r    [tcba_pkg::NCH];
  logic [tcba_pkg::CUR_W-1:0] cur_r    [tcba_pkg::NCH];

  always_comb begin
    for (int c = 0; c < tcba_pkg::NCH; c++) begin
      held_nxt[c] = held_r[c];
      if (valid && ctrl.capture) begin
        held_nxt[c] = '0;
      end else if (valid && ctrl.fresh) begin
        held_nxt[c] = cur[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      for (int c = 0; c < tcba_pkg::NCH; c++) begin
        held_r[c] <= '0;
      end
    end else if (en) begin
      valid_r <= valid;
      for (int c = 0; c < tcba_pkg::NCH; c++) begin
        held_r[c] <= held_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fresh_r <= valid && ctrl.fresh;
      for (int c = 0; c < tcba_pkg::NCH; c++) begin
        raw_r[c] <= raw[c];
        cur_r[c] <= held_nxt[c];
      end
    end
  end

  assign out_valid = valid_r;
  assign out_fresh = fresh_r;
  assign out_raw   = raw_r;
  assign out_cur   = cur_r;

endmodule

FILE: rtl/three_channel_current_block_averager.sv
// Top level of the three-channel current averager: handshakes, window
// counter, gain register, three tcba_lane copies and tcba_merge.
// Depends on tcba_pkg and three_channel_current_block_averager_assert.svh.

// Each input item carries three ADC samples and a command flag. A capture
// stores the samples as zero offsets and clears sums, counter and currents.
// Samples are summed per channel; every WINDOW samples each channel produces
// (sum - WINDOW*offset) * gain_q24 / 2^24, rounded, clamped at zero and
// saturated at 65535, and held until the next window. One result item leaves
// for each input item, and a new item is taken every cycle: the three lanes
// are a four-stage pipeline (accumulate, offset subtract, multiply, round
// and merge) that only holds when the output register is full and not taken.
// gain_q24 should be written only while no item is in flight.
module three_channel_current_block_averager #(
  parameter int WINDOW = tcba_pkg::WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // adc_1 [15:0], adc_2 [31:16], adc_3 [47:32]
  input  logic [0:0]  in_tuser,   // cmd [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // raw_1, raw_2, raw_3, current_1, current_2,
                                  // current_3, 16 bits each from bit 0 up
  output logic [0:0]  out_tuser,  // fresh [0]
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [23:0] cfg_tdata   // gain_q24 [23:0]
);

  localparam int CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

  logic                         en;
  logic                         accept;
  logic                         capture;
  logic                         close;
  logic [CNT_W-1:0]             cnt_r;
  logic [tcba_pkg::GAIN_W-1:0]  gain_r;
  logic                         v1_r, v2_r, v3_r;
  tcba_pkg::ctrl_t              c1_r, c2_r, c3_r;
  logic [tcba_pkg::ADC_W-1:0]   adc      [tcba_pkg::NCH];
  logic [tcba_pkg::ADC_W-1:0]   lane_raw [tcba_pkg::NCH];
  logic [tcba_pkg::CUR_W-1:0]   lane_cur [tcba_pkg::NCH];
  logic [tcba_pkg::ADC_W-1:0]   o_raw    [tcba_pkg::NCH];
  logic [tcba_pkg::CUR_W-1:0]   o_cur    [tcba_pkg::NCH];
  logic                         o_fresh;

  assign en         = !out_tvalid || out_tready;
  assign in_tready  = en;
  assign accept     = in_tvalid && en;
  assign capture    = (tcba_pkg::cmd_t'(in_tuser[0]) == tcba_pkg::CMD_CAPTURE);
  assign close      = !capture && (cnt_r == CNT_LAST);
  assign cfg_tready = 1'b1;

  assign adc[0] = in_tdata[15:0];
  assign adc[1] = in_tdata[31:16];
  assign adc[2] = in_tdata[47:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= tcba_pkg::GAIN_RESET;
    end else if (cfg_tvalid) begin
      gain_r <= cfg_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      if (capture || close) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r <= '{capture: capture, fresh: close};
      c2_r <= c1_r;
      c3_r <= c2_r;
    end
  end

  for (genvar g = 0; g < tcba_pkg::NCH; g++) begin : g_lane
    tcba_lane #(
      .WINDOW (WINDOW)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .accept  (accept),
      .capture (capture),
      .close   (close),
      .adc     (adc[g]),
      .gain    (gain_r),
      .raw     (lane_raw[g]),
      .cur     (lane_cur[g])
    );
  end

  tcba_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid     (v3_r),
    .ctrl      (c3_r),
    .raw       (lane_raw),
    .cur       (lane_cur),
    .out_valid (out_tvalid),
    .out_raw   (o_raw),
    .out_cur   (o_cur),
    .out_fresh (o_fresh)
  );

  assign out_tdata = {o_cur[2], o_cur[1], o_cur[0], o_raw[2], o_raw[1], o_raw[0]};
  assign out_tuser = o_fresh;

`include "three_channel_current_block_averager_assert.svh"

  `TCBA_ASSERT_NOW(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CNT_LAST)
  `TCBA_ASSERT_NEXT(a_capture_clears_cnt, clk, rst_n, accept && capture, cnt_r == '0)
  `TCBA_ASSERT_NEXT(a_stage_to_out, clk, rst_n, en && v3_r, out_tvalid)

endmodule

FILE: tb/sv/three_channel_current_block_averager_tb.sv
// Self-checking testbench for three_channel_current_block_averager.
// Depends on tcba_pkg and the averager RTL; predicts every result item and
// compares it with what leaves the output stream, under random backpressure.
module three_channel_current_block_averager_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW     = tcba_pkg::WINDOW_DEF;
  localparam int LATENCY    = 4;
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_STALL = 300;
  localparam int MAX_WAIT   = 8;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    tcba_pkg::cmd_t    cmd;
    logic [2:0][15:0]  adc;
  } sample_set_t;

  typedef struct packed {
    logic [2:0][15:0] raw;
    logic [2:0][15:0] current;
    logic             fresh;
  } averager_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // adc_1 [15:0], adc_2 [31:16], adc_3 [47:32]
  logic [0:0]  in_tuser;   // cmd [0]
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;  // raw_1..raw_3, current_1..current_3, 16 bits each
  logic [0:0]  out_tuser;  // fresh [0]
  logic        cfg_tvalid;
  logic        cfg_tready;
  logic [23:0] cfg_tdata;  // gain_q24 [23:0]

  three_channel_current_block_averager #(.WINDOW(WINDOW)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_tvalid(cfg_tvalid),
    .cfg_tready(cfg_tready),
    .cfg_tdata (cfg_tdata)
  );

  // Predictor state.
  int unsigned      acc_sum [3];
  int unsigned      acc_count;
  logic [15:0]      zero_count [3];
  logic [15:0]      held_amps [3];
  logic [23:0]      gain_setting;

  sample_set_t      sets_to_send [$];
  averager_result_t results_due [$];

  // Handshakes seen at the last rising edge, read by the falling-edge drivers.
  bit in_fire, out_fire, cfg_fire;
  bit no_idle;
  bit long_stall_req;
  int in_gap, out_wait, out_hold;
  int idle_cycles;
  int queued_total, checked_total;
  int mismatches, unexpected;
  int sample_sets_sent, captures_sent, fresh_seen, gain_writes;

  function automatic logic [15:0] scale_to_amps(int unsigned sum, logic [15:0] offset,
                                                logic [23:0] gain);
    longint delta;
    longint prod;
    longint q;
    delta = longint'(sum) - longint'(WINDOW) * longint'(offset);
    if (delta <= 0) return 16'd0;
    prod = delta * longint'(gain);
    q = (prod + (longint'(1) <<< 23)) >>> 24;
    if (q > 65535) return 16'hFFFF;
    return q[15:0];
  endfunction

  function automatic averager_result_t average_sample_set(sample_set_t s);
    averager_result_t r;
    r = '0;
    if (s.cmd == tcba_pkg::CMD_CAPTURE) begin
      for (int c = 0; c < 3; c++) begin
        zero_count[c] = s.adc[c];
        acc_sum[c]    = 0;
        held_amps[c]  = 16'd0;
      end
      acc_count = 0;
    end else begin
      for (int c = 0; c < 3; c++) begin
        acc_sum[c] += s.adc[c];
        r.raw[c] = s.adc[c];
      end
      acc_count++;
      if (acc_count >= WINDOW) begin
        for (int c = 0; c < 3; c++) begin
          held_amps[c] = scale_to_amps(acc_sum[c], zero_count[c], gain_setting);
          acc_sum[c]   = 0;
        end
        acc_count = 0;
        r.fresh   = 1'b1;
      end
    end
    for (int c = 0; c < 3; c++) r.current[c] = held_amps[c];
    return r;
  endfunction

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Counts near the captured offset reach both the clamp and small currents.
  function automatic logic [15:0] pick_count(logic [15:0] centre);
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3, 4: return centre + 16'($urandom_range(0, 600)) - 16'd300;
      default: return 16'($urandom);
    endcase
  endfunction

  initial clk = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sender: presents queued items, waiting a drawn number of cycles after each.
  always @(negedge clk) begin : sender
    sample_set_t s;
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (sets_to_send.size() > 0) begin
        s = sets_to_send.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= s.adc;
        in_tuser  <= s.cmd;
        in_gap    = draw_wait();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: after each taken item it holds tready low for a drawn wait.
  always @(negedge clk) begin : receiver
    if (rst_n) begin
      if (long_stall_req) begin
        out_hold = LONG_STALL;
        long_stall_req = 1'b0;
      end
      if (out_fire) out_wait = draw_wait();
      if (out_hold > 0) begin
        out_hold--;
        out_tready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    sample_set_t      s;
    averager_result_t want, got;
    logic [15:0]      want_f [7];
    logic [15:0]      got_f [7];
    string            names [7];
    names = '{"raw_1", "raw_2", "raw_3", "current_1", "current_2", "current_3", "fresh"};
    in_fire  = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    cfg_fire = rst_n && cfg_tvalid && cfg_tready;
    if (cfg_fire) gain_setting = cfg_tdata;
    if (in_fire) begin
      s.adc = in_tdata;
      s.cmd = tcba_pkg::cmd_t'(in_tuser[0]);
      results_due.push_back(average_sample_set(s));
    end
    if (out_fire) begin
      got.raw     = out_tdata[47:0];
      got.current = out_tdata[95:48];
      got.fresh   = out_tuser[0];
      if (results_due.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= REPORT_MAX)
          $display("%0t: result item with nothing expected: %h %b", $realtime,
                   out_tdata, out_tuser);
      end else begin
        want = results_due.pop_front();
        checked_total++;
        if (got.fresh) fresh_seen++;
        for (int c = 0; c < 3; c++) begin
          want_f[c]     = want.raw[c];
          got_f[c]      = got.raw[c];
          want_f[3 + c] = want.current[c];
          got_f[3 + c]  = got.current[c];
        end
        want_f[6] = {15'd0, want.fresh};
        got_f[6]  = {15'd0, got.fresh};
        for (int k = 0; k < 7; k++) begin
          if (want_f[k] !== got_f[k]) begin
            mismatches++;
            if (mismatches + unexpected <= REPORT_MAX)
              $display("%0t: result %0d field %s expected %0d got %0d", $realtime,
                       checked_total, names[k], want_f[k], got_f[k]);
          end
        end
      end
    end
    if (in_fire || out_fire || cfg_fire || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles without a handshake", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic queue_set(tcba_pkg::cmd_t cmd, logic [15:0] a1, logic [15:0] a2,
                           logic [15:0] a3);
    sample_set_t s;
    s.cmd = cmd;
    s.adc = {a3, a2, a1};
    sets_to_send.push_back(s);
    queued_total++;
    if (cmd == tcba_pkg::CMD_CAPTURE) captures_sent++;
    else sample_sets_sent++;
  endtask

  // Waits until every queued item has come back, then lets the pipeline settle.
  task automatic drain();
    while (checked_total != queued_total) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_gain(logic [23:0] gain);
    @(negedge clk);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= gain;
    do @(negedge clk); while (!cfg_fire);
    cfg_tvalid <= 1'b0;
    gain_writes++;
  endtask

  // Random sample sets, some near the last captured offsets, and occasional captures.
  task automatic random_phase(int n);
    logic [15:0] centre [3];
    logic [15:0] a [3];
    centre = '{zero_count[0], zero_count[1], zero_count[2]};
    for (int i = 0; i < n; i++) begin
      for (int c = 0; c < 3; c++) a[c] = pick_count(centre[c]);
      if ($urandom_range(0, 39) == 0) begin
        queue_set(tcba_pkg::CMD_CAPTURE, a[0], a[1], a[2]);
        centre = a;
      end else begin
        queue_set(tcba_pkg::CMD_SAMPLE, a[0], a[1], a[2]);
      end
    end
  endtask

  initial begin
    logic [23:0] gains [6];
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    cfg_tvalid  = 1'b0;
    cfg_tdata   = '0;
    gain_setting = tcba_pkg::GAIN_RESET;
    acc_count   = 0;
    for (int c = 0; c < 3; c++) begin
      acc_sum[c]    = 0;
      zero_count[c] = 16'd0;
      held_amps[c]  = 16'd0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset gain. Before any capture the offsets are
    // zero, so full-scale counts give the largest current this gain allows.
    for (int i = 0; i < WINDOW; i++)
      queue_set(tcba_pkg::CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // A capture in the middle of a window discards the partial sums.
    for (int i = 0; i < 3; i++)
      queue_set(tcba_pkg::CMD_SAMPLE, 16'h1234, 16'h0000, 16'hFFFF);
    queue_set(tcba_pkg::CMD_CAPTURE, 16'h8000, 16'hFFFF, 16'h0000);
    // Channel one above its offset, channel two below it and clamped to zero,
    // channel three one count above a zero offset so rounding decides.
    for (int i = 0; i < WINDOW; i++)
      queue_set(tcba_pkg::CMD_SAMPLE, 16'hFFFF, (i % 2) ? 16'h0000 : 16'hFFFF, 16'h0001);
    queue_set(tcba_pkg::CMD_CAPTURE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(220);
    drain();

    // The largest gain saturates, zero and one give vanishing currents.
    gains = '{24'hFFFFFF, 24'h000000, 24'h000001, 24'($urandom),
              24'($urandom_range(0, 24'h1FFFFF)), tcba_pkg::GAIN_RESET};
    for (int p = 0; p < 6; p++) begin
      write_gain(gains[p]);
      if (p == 1) begin
        // Receiver stalls for a long stretch while the sender offers items
        // back to back, so the pipeline fills and holds its input.
        no_idle = 1'b1;
        long_stall_req = 1'b1;
      end
      random_phase(240);
      drain();
      no_idle = 1'b0;
    end

    repeat (LATENCY + 4) @(negedge clk);
    $display("Sent %0d sample sets and %0d captures under %0d gain writes;",
             sample_sets_sent, captures_sent, gain_writes);
    $display("checked %0d result items, %0d with freshly computed currents.",
             checked_total, fresh_seen);
    if (mismatches == 0 && unexpected == 0 && results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d field mismatches, %0d unexpected items, %0d items missing",
               mismatches, unexpected, results_due.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
